// ===== sv/spr_pkg.sv =====
// spr_pkg: shared types and constants of the streaming pattern replace block
// beat payload structs, cell control/status structs, register indexes
// no dependencies
package spr_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 4;
    localparam int WORD_W  = 64;
    localparam int WORD_BYTES = WORD_W / BYTE_W;
    localparam int REG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    typedef logic [WORD_BYTES-1:0][BYTE_W-1:0] text_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              line_end;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic eq;
        logic eq_prev;
    } cell_stat_t;

endpackage

// ===== sv/streaming_pattern_replace.sv =====
// streaming_pattern_replace: top level, find and replace over a byte stream
// row of spr_cell instances holding the partial match, control fsm, output register
// depends on spr_pkg and spr_cell
//
//   channel  direction  handshake             payload
//   in       in         in_valid / in_ready   in_data   (in_byte, line_end)
//   out      out        out_valid / out_ready out_data  (out_byte, last)
//   cfg      in         cfg_en                cfg_index, cfg_data
//
// one item at a time: an accept in idle, then a scan of the held bytes against the pattern;
// output beats go one per cycle while out is not stalled; a match emits the replacement
// bytes, and each mismatch shifts the cell row by one byte and emits the front byte
// a line end emits every held byte and then a newline beat
// out stalls hold the fsm; rst_n clears control state and config registers
module streaming_pattern_replace
    import spr_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(MAX_TEXT_LEN + 1);
    localparam int RIDX_W = $clog2(WORD_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TEXT_LEN);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_REPL  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = LEN_W'(1);
        end
        else if (v > MAX_LEN)
        begin
            r = MAX_LEN;
        end
        return r;
    endfunction

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RIDX_W-1:0] ridx_reg, ridx_next;
    text_word_t        pat_reg, rep_reg;
    logic [LEN_W-1:0]  plen_reg, rlen_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [BYTE_W-1:0] cell_byte [MAX_TEXT_LEN];
    cell_stat_t        cell_stat [MAX_TEXT_LEN];
    cell_ctrl_t        cell_ctrl [MAX_TEXT_LEN];

    logic              load_en, shift_en, emit, slot_free;
    out_item_t         emit_item;
    logic              match_all, match_shift, prefix, prefix_shift, done;
    logic [CNT_W-1:0]  cnt_m1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            rep_reg  <= '0;
            plen_reg <= LEN_W'(1);
            rlen_reg <= LEN_W'(1);
        end
        else if (cfg_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:      pat_reg  <= text_word_t'(cfg_data);
                REG_PATTERN_LENGTH:     plen_reg <= clamp_len(cfg_data[LEN_W-1:0]);
                REG_REPLACEMENT_BYTES:  rep_reg  <= text_word_t'(cfg_data);
                REG_REPLACEMENT_LENGTH: rlen_reg <= clamp_len(cfg_data[LEN_W-1:0]);
                default: ;
            endcase
        end
    end

    // cell row
    for (genvar g = 0; g < MAX_TEXT_LEN; g++)
    begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        logic [BYTE_W-1:0] nbr_byte;

        if (g == MAX_TEXT_LEN - 1)
        begin : g_end
            assign nbr_byte = '0;
        end
        else
        begin : g_mid
            assign nbr_byte = cell_byte[g+1];
        end

        assign cell_ctrl[g].load  = load_en && (cnt_reg == CNT_W'(g));
        assign cell_ctrl[g].shift = shift_en;

        spr_cell u_cell (
            .clk           (clk),
            .ctrl          (cell_ctrl[g]),
            .load_byte     (in_data.in_byte),
            .next_byte     (nbr_byte),
            .pat_byte      (pat_reg[g]),
            .prev_pat_byte (pat_reg[PREV]),
            .held_byte     (cell_byte[g]),
            .stat          (cell_stat[g])
        );
    end

    // prefix checks on held bytes and on held bytes after one shift
    always_comb
    begin
        match_all   = 1'b1;
        match_shift = 1'b1;
        for (int i = 0; i < MAX_TEXT_LEN; i++)
        begin
            if (CNT_W'(i) < cnt_reg)
            begin
                match_all = match_all & cell_stat[i].eq;
                if (i > 0)
                begin
                    match_shift = match_shift & cell_stat[i].eq_prev;
                end
            end
        end
    end

    assign cnt_m1       = cnt_reg - CNT_W'(1);
    assign prefix       = (LEN_W'(cnt_reg) <= plen_reg) && match_all;
    assign prefix_shift = (LEN_W'(cnt_m1) <= plen_reg) && match_shift;
    assign done         = (cnt_m1 == '0) || (prefix_shift && (LEN_W'(cnt_m1) != plen_reg));
    assign slot_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ridx_next  = ridx_reg;
        load_en    = 1'b0;
        shift_en   = 1'b0;
        emit       = 1'b0;
        emit_item  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.line_end)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        load_en    = 1'b1;
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (prefix)
                begin
                    if (LEN_W'(cnt_reg) == plen_reg)
                    begin
                        cnt_next   = '0;
                        ridx_next  = '0;
                        state_next = S_REPL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (slot_free)
                begin
                    emit               = 1'b1;
                    emit_item.out_byte = cell_byte[0];
                    emit_item.last     = done;
                    shift_en           = 1'b1;
                    cnt_next           = cnt_m1;
                end
            end
            S_REPL:
            begin
                if (slot_free)
                begin
                    emit               = 1'b1;
                    emit_item.out_byte = rep_reg[ridx_reg];
                    emit_item.last     = (LEN_W'(ridx_reg) + LEN_W'(1) == rlen_reg);
                    if (emit_item.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ridx_next = ridx_reg + RIDX_W'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (cnt_reg != '0)
                    begin
                        emit_item.out_byte = cell_byte[0];
                        emit_item.last     = 1'b0;
                        shift_en           = 1'b1;
                        cnt_next           = cnt_m1;
                    end
                    else
                    begin
                        emit_item.out_byte = NEWLINE;
                        emit_item.last     = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ridx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ridx_reg  <= ridx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= emit_item;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_cnt_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> cnt_reg < CNT_W'(MAX_TEXT_LEN))
        else $error("held byte count exceeds row depth");

    a_ridx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REPL |-> LEN_W'(ridx_reg) < rlen_reg)
        else $error("replacement index beyond replacement length");

    a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH && cnt_reg == '0 && slot_free
        |=> out_valid_reg && out_reg.last && out_reg.out_byte == NEWLINE)
        else $error("line end did not close with a newline beat");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("accepted item left no work");
`endif

endmodule

// ===== sv/spr_cell.sv =====
// spr_cell: one byte position of the candidate row
// holds a byte, shifts from its right neighbour, compares against the pattern
// depends on spr_pkg
module spr_cell
    import spr_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] load_byte,
    input  logic [BYTE_W-1:0] next_byte,
    input  logic [BYTE_W-1:0] pat_byte,
    input  logic [BYTE_W-1:0] prev_pat_byte,
    output logic [BYTE_W-1:0] held_byte,
    output cell_stat_t        stat
);

    logic [BYTE_W-1:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            byte_reg <= load_byte;
        end
        else if (ctrl.shift)
        begin
            byte_reg <= next_byte;
        end
    end

    assign held_byte    = byte_reg;
    assign stat.eq      = (byte_reg == pat_byte);
    assign stat.eq_prev = (byte_reg == prev_pat_byte);

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for streaming_pattern_replace, directed table then random phases
// predicts the rewritten byte stream, drives beats at the falling edge, checks at the rising edge
// depends on spr_pkg and streaming_pattern_replace
`timescale 1ns / 1ps

module tb;
    import spr_pkg::*;

    localparam int MAX_TEXT_LEN   = 8;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 60;
    localparam int REPORT_LIMIT   = 10;

    typedef enum logic { ROW_TEXT, ROW_REGS } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        in_item_t    item;
        bit          typed;
        logic [7:0]  want;
        text_word_t  pat;
        logic [3:0]  plen;
        text_word_t  rep;
        logic [3:0]  rlen;
    } dir_row_t;

    typedef logic [7:0] byte_q_t[$];

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_en;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    // predictor state
    text_word_t pat_word;
    text_word_t rep_word;
    int         pat_len;
    int         rep_len;
    byte_q_t    held;

    out_item_t  pending_beats[$];

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int mismatches;
    int beats_seen;
    int items_sent;
    int lines_sent;
    int reg_loads;
    int quiet;

    streaming_pattern_replace #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_length(input logic [3:0] v);
        if (v == 4'd0)
            return 1;
        if (v > MAX_TEXT_LEN)
            return MAX_TEXT_LEN;
        return int'(v);
    endfunction

    function automatic in_item_t text_item(input logic [7:0] b, input logic e);
        in_item_t it;
        it.in_byte  = b;
        it.line_end = e;
        return it;
    endfunction

    function automatic dir_row_t text_row(input logic [7:0] b, input logic e,
                                          input bit typed = 1'b0, input logic [7:0] want = 8'h00);
        dir_row_t row;
        row.kind  = ROW_TEXT;
        row.item  = text_item(b, e);
        row.typed = typed;
        row.want  = want;
        row.pat   = '0;
        row.plen  = '0;
        row.rep   = '0;
        row.rlen  = '0;
        return row;
    endfunction

    function automatic dir_row_t regs_row(input text_word_t p, input logic [3:0] pl,
                                          input text_word_t r, input logic [3:0] rl);
        dir_row_t row;
        row.kind  = ROW_REGS;
        row.item  = text_item(8'h00, 1'b0);
        row.typed = 1'b0;
        row.want  = 8'h00;
        row.pat   = p;
        row.plen  = pl;
        row.rep   = r;
        row.rlen  = rl;
        return row;
    endfunction

    // output bytes caused by one input item; updates the held partial match
    function automatic void rewrite_text(input in_item_t it, output byte_q_t beats);
        byte_q_t work;
        bit      is_prefix;
        beats = {};
        if (it.line_end)
        begin
            beats = held;
            beats.push_back(NEWLINE);
            held = {};
        end
        else
        begin
            work = held;
            work.push_back(it.in_byte);
            while (work.size() > 0)
            begin
                is_prefix = (work.size() <= pat_len);
                for (int i = 0; is_prefix && i < work.size(); i++)
                    if (work[i] != pat_word[i])
                        is_prefix = 1'b0;
                if (is_prefix)
                begin
                    if (work.size() == pat_len)
                    begin
                        for (int i = 0; i < rep_len; i++)
                            beats.push_back(rep_word[i]);
                        work = {};
                    end
                    break;
                end
                beats.push_back(work.pop_front());
            end
            held = work;
        end
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t mismatch: %s", $realtime, what);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer(input in_item_t it, input bit typed = 1'b0, input logic [7:0] want = 8'h00);
        byte_q_t   beats;
        out_item_t e;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rewrite_text(it, beats);
        if (typed)
            beats = {want};
        foreach (beats[k])
        begin
            e.out_byte = beats[k];
            e.last     = (k == beats.size() - 1);
            pending_beats.push_back(e);
        end
        items_sent++;
        if (it.line_end)
            lines_sent++;
        @(negedge clk);
    endtask

    // sender pauses until every expected beat is out and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_regs(input text_word_t p, input logic [3:0] pl,
                             input text_word_t r, input logic [3:0] rl);
        cfg_en    <= 1'b1;
        cfg_index <= REG_PATTERN_BYTES;
        cfg_data  <= p;
        @(negedge clk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data  <= {{(WORD_W-4){1'b0}}, pl};
        @(negedge clk);
        cfg_index <= REG_REPLACEMENT_BYTES;
        cfg_data  <= r;
        @(negedge clk);
        cfg_index <= REG_REPLACEMENT_LENGTH;
        cfg_data  <= {{(WORD_W-4){1'b0}}, rl};
        @(negedge clk);
        cfg_en   <= 1'b0;
        pat_word = p;
        pat_len  = clamp_length(pl);
        rep_word = r;
        rep_len  = clamp_length(rl);
        reg_loads++;
        @(negedge clk);
    endtask

    task automatic run_phase(input int ph);
        logic [7:0] alpha [3];
        text_word_t p;
        text_word_t r;
        logic [3:0] pl;
        logic [3:0] rl;
        int         sent;
        int         pick;
        int         n;
        settle();
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
        foreach (alpha[k])
        begin
            pick = $urandom_range(9);
            alpha[k] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
        end
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            p[k] = alpha[$urandom_range(2)];
            r[k] = 8'($urandom_range(255));
        end
        pick = $urandom_range(9);
        pl = (pick == 0) ? 4'($urandom_range(15)) : (pick == 1) ? 4'd8 : 4'($urandom_range(4, 1));
        rl = 4'($urandom_range(15));
        load_regs(p, pl, r, rl);
        if (ph % 4 == 0)
            hold_req = 1'b1;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                for (int k = 0; k < pat_len; k++)
                    offer(text_item(pat_word[k], 1'b0));
                sent += pat_len;
            end
            else if (pick < 60)
            begin
                n = $urandom_range(pat_len, 1);
                for (int k = 0; k < n; k++)
                    offer(text_item(pat_word[k], 1'b0));
                sent += n;
            end
            else if (pick < 82)
            begin
                offer(text_item(alpha[$urandom_range(2)], 1'b0));
                sent++;
            end
            else if (pick < 92)
            begin
                offer(text_item(8'($urandom_range(255)), 1'b0));
                sent++;
            end
            else
            begin
                offer(text_item(8'($urandom_range(255)), 1'b1));
                sent++;
            end
        end
    endtask

    // receiver, with a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (pending_beats.size() == 0)
                note_mismatch($sformatf("unexpected beat byte %02h last %0b",
                                        out_data.out_byte, out_data.last));
            else
            begin
                want = pending_beats.pop_front();
                if (out_data.out_byte !== want.out_byte || out_data.last !== want.last)
                    note_mismatch($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
                                            want.out_byte, out_data.out_byte,
                                            want.last, out_data.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d beats outstanding",
                         quiet, pending_beats.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t rows[$];
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_en         = 1'b0;
        cfg_index      = REG_PATTERN_BYTES;
        cfg_data       = '0;
        rst_n          = 1'b0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        beats_seen     = 0;
        items_sent     = 0;
        lines_sent     = 0;
        reg_loads      = 0;
        quiet          = 0;
        pat_word       = '0;
        pat_len        = 1;
        rep_word       = '0;
        rep_len        = 1;
        held           = {};

        // after reset: pattern and replacement are a single zero byte
        rows.push_back(text_row(8'h00, 1'b0, 1'b1, 8'h00));
        rows.push_back(text_row(8'hFF, 1'b0, 1'b1, 8'hFF));
        rows.push_back(text_row(8'hFF, 1'b1, 1'b1, NEWLINE));
        // longest pattern and replacement, full match then broken prefix
        rows.push_back(regs_row(64'h6867_6665_6463_6261, 4'd8, 64'h4847_4645_4443_4241, 4'd8));
        for (int k = 0; k < 8; k++)
            rows.push_back(text_row(8'h61 + 8'(k), 1'b0));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h62, 1'b0));
        rows.push_back(text_row(8'h78, 1'b0));
        // lengths clamped, high pattern bytes ignored
        rows.push_back(regs_row(64'hFFFF_FFFF_FFFF_FF5A, 4'd0, 64'h0, 4'd15));
        rows.push_back(text_row(8'h5A, 1'b0));
        rows.push_back(text_row(8'h00, 1'b1, 1'b1, NEWLINE));
        // seven bytes held, then pattern swapped mid-line: fifteen beats
        rows.push_back(regs_row(64'h6867_6665_6463_6261, 4'd8, 64'h5A, 4'd1));
        for (int k = 0; k < 7; k++)
            rows.push_back(text_row(8'h61 + 8'(k), 1'b0));
        rows.push_back(regs_row(64'h68, 4'd1, 64'h4847_4645_4443_4241, 4'd8));
        rows.push_back(text_row(8'h68, 1'b0));
        // line end flushes a held byte
        rows.push_back(regs_row(64'h6261, 4'd2, 64'h51, 4'd1));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h00, 1'b1));

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REGS)
            begin
                settle();
                load_regs(rows[i].pat, rows[i].plen, rows[i].rep, rows[i].rlen);
            end
            else
                offer(rows[i].item, rows[i].typed, rows[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
            run_phase(ph);

        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d input beats (%0d line ends) over %0d register settings",
                 items_sent, lines_sent, reg_loads);
        $display("run: %0d output beats checked, %0d mismatches", beats_seen, mismatches);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
